[hw/rtl/crx_pkg.sv]
// Shared types and constants for the coded frame receiver.
package crx_pkg;

  localparam int unsigned FRAME_DEPTH_DEF = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned MISS_W          = 4;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CODE_POS        = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_CHAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd2;
  localparam logic [BYTE_W-1:0] STOP_CHAR_RST  = 8'd3;
  localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 4'd8;

  // Request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_STORED     = 3'd0,
    ST_IGNORED    = 3'd1,
    ST_FRAME_DONE = 3'd2,
    ST_FRAME_BYTE = 3'd3,
    ST_MISMATCH   = 3'd4,
    ST_UNLOCKED   = 3'd5,
    ST_NONE       = 3'd6
  } crx_status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic rd_issue;  // read the frame store at the readout counter
    logic rd_emit;   // load the fetched byte into the output register
  } crx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rd_start;  // current input is a matching read request
    logic out_free;  // output register can take a new result
    logic rd_last;   // readout counter is at the final stored byte
  } crx_sts_t;

endpackage

[hw/rtl/crx_ctrl.sv]
// Controller state machine: input handshake and frame readout sequencing.
module crx_ctrl
  import crx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  crx_sts_t sts_i,
  output crx_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o   = !sts_i.out_free;
        cmd_o.accept = in_valid_i && sts_i.out_free;
        if (cmd_o.accept && sts_i.rd_start) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.rd_emit = 1'b1;
          state_d       = sts_i.rd_last ? S_IDLE : S_ISSUE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/crx_dp.sv]
// Datapath: configuration, frame store, frame state and output register.
module crx_dp
  import crx_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 req_type_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic [BYTE_W-1:0]    want_code_i,
  input  crx_cmd_t             cmd_i,
  output crx_sts_t             sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [BYTE_W-1:0]    data_byte_o,
  output logic                 last_o,
  output logic                 overflow_o
);

  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam int unsigned IW = $clog2(FRAME_DEPTH + 1);
  localparam logic [IW-1:0] DEPTH_IDX = IW'(FRAME_DEPTH);
  localparam logic [IW-1:0] CODE_IDX  = IW'(CODE_POS);

  // Configuration registers
  logic [BYTE_W-1:0] start_char_q, stop_char_q;
  logic [MISS_W-1:0] miss_limit_q;

  // Frame state
  logic [BYTE_W-1:0] store_mem [FRAME_DEPTH];
  logic [IW-1:0]     wr_idx_q, wr_idx_d;
  logic              pending_q, pending_d;
  logic [MISS_W-1:0] miss_q, miss_d;
  logic              ovf_q, ovf_d;
  logic [BYTE_W-1:0] code_q;
  logic [IW-1:0]     rd_cnt_q;
  logic [BYTE_W-1:0] rd_data_q;

  // Output register
  logic              out_valid_q;
  crx_status_e       out_status_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q;
  logic              out_ovf_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  crx_status_e       status_d;
  logic [MISS_W-1:0] miss_inc;
  logic              load_single;

  assign miss_inc = miss_q + MISS_W'(1);

  // Status to controller
  assign sts_o.rd_start = (req_type_i == REQ_READ) && pending_q && (code_q == want_code_i);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.rd_last  = (rd_cnt_q + IW'(1)) == wr_idx_q;

  // Work out the effect of one input transaction
  always_comb begin
    wr_idx_d  = wr_idx_q;
    pending_d = pending_q;
    miss_d    = miss_q;
    ovf_d     = ovf_q;
    mem_we    = 1'b0;
    mem_waddr = wr_idx_q[AW-1:0];
    status_d  = ST_STORED;
    if (req_type_i == REQ_BYTE) begin
      if (pending_q) begin
        status_d = ST_IGNORED;
      end else if (rx_byte_i == start_char_q) begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        wr_idx_d  = IW'(1);
        ovf_d     = 1'b0;
      end else begin
        if (wr_idx_q != DEPTH_IDX) begin
          mem_we   = 1'b1;
          wr_idx_d = wr_idx_q + IW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        if ((rx_byte_i == stop_char_q) && (wr_idx_q > CODE_IDX)) begin
          pending_d = 1'b1;
          status_d  = ST_FRAME_DONE;
        end
      end
    end else begin
      if (!pending_q) begin
        status_d = ST_NONE;
      end else if (code_q == want_code_i) begin
        pending_d = 1'b0;
        miss_d    = '0;
        status_d  = ST_FRAME_BYTE;
      end else if (miss_inc == miss_limit_q) begin
        pending_d = 1'b0;
        miss_d    = '0;
        status_d  = ST_UNLOCKED;
      end else begin
        miss_d   = miss_inc;
        status_d = ST_MISMATCH;
      end
    end
  end

  assign load_single = cmd_i.accept && !sts_o.rd_start;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= START_CHAR_RST;
      stop_char_q  <= STOP_CHAR_RST;
      miss_limit_q <= MISS_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_CHAR: start_char_q <= cfg_data_i;
        CFG_STOP_CHAR:  stop_char_q  <= cfg_data_i;
        CFG_MISS_LIMIT: miss_limit_q <= cfg_data_i[MISS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Frame control state and readout counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      pending_q <= 1'b0;
      miss_q    <= '0;
      ovf_q     <= 1'b0;
      rd_cnt_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        wr_idx_q  <= wr_idx_d;
        pending_q <= pending_d;
        miss_q    <= miss_d;
        ovf_q     <= ovf_d;
      end
      if (cmd_i.accept && sts_o.rd_start) begin
        rd_cnt_q <= '0;
      end else if (cmd_i.rd_emit) begin
        rd_cnt_q <= rd_cnt_q + IW'(1);
      end
    end
  end

  // Write the frame store; keep a copy of the code byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && mem_we) begin
      store_mem[mem_waddr] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && mem_we && (mem_waddr == AW'(CODE_POS))) begin
      code_q <= rx_byte_i;
    end
  end

  // Fetch a frame byte for readout
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_data_q <= store_mem[rd_cnt_q[AW-1:0]];
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_single || cmd_i.rd_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load_single) begin
      out_status_q <= status_d;
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
      out_ovf_q    <= ovf_d;
    end else if (cmd_i.rd_emit) begin
      out_status_q <= ST_FRAME_BYTE;
      out_data_q   <= rd_data_q;
      out_last_q   <= sts_o.rd_last;
      out_ovf_q    <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_byte_o = out_data_q;
  assign last_o      = out_last_q;
  assign overflow_o  = out_ovf_q;

endmodule

[hw/rtl/coded_frame_receiver.sv]
// Coded frame receiver top level: controller and datapath.
// A received byte or a non-matching read shows its result in the cycle after acceptance.
// One such transaction is taken per cycle while the output is taken.
// A matching read streams the stored frame byte by byte (store read, then output load),
// and input stays stalled until the last byte is loaded.
// Reset clears control state and loads register defaults; frame store contents stay undefined.
module coded_frame_receiver
  import crx_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic [BYTE_W-1:0]    want_code_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [BYTE_W-1:0]    data_byte_o,
  output logic                 last_o,
  output logic                 overflow_o
);

  crx_cmd_t cmd;
  crx_sts_t sts;

  crx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crx_dp #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_type_i  (req_type_i),
    .rx_byte_i   (rx_byte_i),
    .want_code_i (want_code_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

endmodule

[hw/rtl/crx_checker.sv]
// Port-level checker for the coded frame receiver and its bind.
module crx_checker
  import crx_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [STATUS_W-1:0]  status_o,
  input logic [BYTE_W-1:0]    data_byte_o,
  input logic                 last_o,
  input logic                 overflow_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(data_byte_o)
      && $stable(last_o) && $stable(overflow_o))
    else $error("stalled output transaction changed");

  // Only frame bytes carry data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FRAME_BYTE) |-> (data_byte_o == '0))
    else $error("data on a non-frame-byte result");

  // Single results always close their transaction
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FRAME_BYTE) |-> last_o)
    else $error("single result without last");

  // A frame byte not marked last is followed by more frame bytes; input opens
  // only once the final byte sits in the output register
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (status_o == ST_FRAME_BYTE) && !last_o
      |=> in_stall_o || (out_valid_o && (status_o == ST_FRAME_BYTE) && last_o))
    else $error("input taken in the middle of a frame readout");

endmodule

bind coded_frame_receiver crx_checker u_crx_checker (.*);

[test/coded_frame_receiver_tb.sv]
// Self-checking testbench for the coded frame receiver: directed and random frame traffic.
`timescale 1ns / 100ps

module coded_frame_receiver_tb;
  import crx_pkg::*;

  localparam int unsigned DEPTH          = FRAME_DEPTH_DEF;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    crx_status_e        status;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic               ovf;
  } rx_result_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_START_CHAR;
  logic [BYTE_W-1:0]    cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i  = REQ_BYTE;
  logic [BYTE_W-1:0]    rx_byte_i   = '0;
  logic [BYTE_W-1:0]    want_code_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [BYTE_W-1:0]    data_byte_o;
  logic                 last_o;
  logic                 overflow_o;

  // Shadow copy of the receiver state and its registers
  logic [BYTE_W-1:0] store_m [DEPTH];
  int unsigned       wr_idx_m  = 0;
  logic              pend_m    = 1'b0;
  logic [BYTE_W-1:0] code_m    = '0;
  logic [MISS_W-1:0] miss_m    = '0;
  logic              ovf_m     = 1'b0;
  logic [BYTE_W-1:0] start_m   = START_CHAR_RST;
  logic [BYTE_W-1:0] stop_m    = STOP_CHAR_RST;
  logic [MISS_W-1:0] limit_m   = MISS_LIMIT_RST;

  rx_result_t  due_results[$];
  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  logic        no_idle       = 1'b0;
  logic        long_hold_req = 1'b0;

  coded_frame_receiver uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .rx_byte_i   (rx_byte_i),
    .want_code_i (want_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Write one byte into the shadow store, saturating at full depth
  function automatic void store_byte(input logic [BYTE_W-1:0] b);
    if (wr_idx_m < DEPTH) begin
      store_m[wr_idx_m] = b;
      wr_idx_m++;
    end else begin
      wr_idx_m = DEPTH;
      ovf_m    = 1'b1;
    end
  endfunction

  // Advance the shadow state by one transaction and queue the results it causes
  function automatic void predict_frame_rx(input logic rt, input logic [BYTE_W-1:0] rb,
                                           input logic [BYTE_W-1:0] wc);
    crx_status_e st;
    int unsigned n;
    st = ST_STORED;
    if (rt == REQ_BYTE) begin
      if (pend_m) begin
        st = ST_IGNORED;
      end else if (rb == start_m) begin
        wr_idx_m = 0;
        ovf_m    = 1'b0;
        store_byte(rb);
      end else if (rb == stop_m && wr_idx_m > CODE_POS) begin
        store_byte(rb);
        code_m = store_m[CODE_POS];
        pend_m = 1'b1;
        st     = ST_FRAME_DONE;
      end else begin
        store_byte(rb);
      end
      due_results.push_back('{st, '0, 1'b1, ovf_m});
    end else if (!pend_m) begin
      due_results.push_back('{ST_NONE, '0, 1'b1, ovf_m});
    end else if (code_m == wc) begin
      n      = wr_idx_m;
      pend_m = 1'b0;
      miss_m = '0;
      for (int unsigned i = 0; i < n; i++)
        due_results.push_back('{ST_FRAME_BYTE, store_m[i], (i + 1 == n), ovf_m});
    end else begin
      miss_m = miss_m + 1'b1;
      if (miss_m == limit_m) begin
        pend_m = 1'b0;
        miss_m = '0;
        due_results.push_back('{ST_UNLOCKED, '0, 1'b1, ovf_m});
      end else begin
        due_results.push_back('{ST_MISMATCH, '0, 1'b1, ovf_m});
      end
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Byte that is neither marker under the current setting
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == start_m || b == stop_m);
    return b;
  endfunction

  // Offer one transaction, hold it until taken, then predict its results
  task automatic send_item(input logic rt, input logic [BYTE_W-1:0] rb,
                           input logic [BYTE_W-1:0] wc);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= rt;
    rx_byte_i   <= rb;
    want_code_i <= wc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame_rx(rt, rb, wc);
    items_sent++;
  endtask

  // Drop valid and wait until every queued result has come out
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  // Write all three registers while the block is idle
  task automatic load_config(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input logic [MISS_W-1:0] l);
    wait_all_results();
    repeat (2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_START_CHAR;
    cfg_data_i <= s;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_STOP_CHAR;
    cfg_data_i <= e;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MISS_LIMIT;
    cfg_data_i <= BYTE_W'(l);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    start_m = s;
    stop_m  = e;
    limit_m = l;
  endtask

  // Start byte (optional), body with the code at position 2, stop byte
  task automatic send_frame(input logic with_start, input int unsigned body_len,
                            input logic [BYTE_W-1:0] code);
    if (with_start) send_item(REQ_BYTE, start_m, BYTE_W'($urandom));
    for (int unsigned i = 1; i <= body_len; i++)
      send_item(REQ_BYTE, (i == CODE_POS) ? code : plain_byte(), BYTE_W'($urandom));
    send_item(REQ_BYTE, stop_m, BYTE_W'($urandom));
  endtask

  task automatic test_basic_frames();
    load_config(START_CHAR_RST, STOP_CHAR_RST, MISS_LIMIT_RST);
    // reads with nothing pending, extreme field values
    send_item(REQ_READ, 8'h00, 8'h00);
    send_item(REQ_READ, 8'hFF, 8'hFF);
    send_item(REQ_BYTE, 8'h00, 8'hFF);
    send_item(REQ_BYTE, 8'hFF, 8'h00);
    // plain frame, then ignore, miss and match
    send_item(REQ_BYTE, START_CHAR_RST, 8'h00);
    send_item(REQ_BYTE, 8'h41, 8'h00);
    send_item(REQ_BYTE, 8'h5A, 8'h00);
    send_item(REQ_BYTE, STOP_CHAR_RST, 8'h00);
    send_item(REQ_BYTE, 8'hFF, 8'hFF);
    send_item(REQ_READ, 8'h00, 8'h00);
    send_item(REQ_READ, 8'hFF, 8'h5A);
    // stop at a low index is stored as data
    send_item(REQ_BYTE, START_CHAR_RST, 8'h00);
    send_item(REQ_BYTE, STOP_CHAR_RST, 8'h00);
    send_item(REQ_BYTE, 8'hA5, 8'h00);
    send_item(REQ_BYTE, STOP_CHAR_RST, 8'h00);
    send_item(REQ_READ, 8'h00, 8'hA5);
    // no start byte: the next frame continues at the current index
    send_item(REQ_BYTE, 8'h11, 8'h00);
    send_item(REQ_BYTE, STOP_CHAR_RST, 8'h00);
    send_item(REQ_READ, 8'h00, 8'hA5);
  endtask

  task automatic test_overflow();
    send_item(REQ_BYTE, start_m, 8'h00);
    for (int unsigned i = 0; i < DEPTH + 2; i++)
      send_item(REQ_BYTE, 8'h10 + 8'(i * 7), 8'h00);
    send_item(REQ_BYTE, stop_m, 8'h00);
    send_item(REQ_BYTE, 8'h77, 8'h00);
    send_item(REQ_READ, 8'h00, code_m);
    // a start byte clears the overflow flag
    send_item(REQ_BYTE, start_m, 8'h00);
  endtask

  task automatic test_miss_limit();
    load_config(8'h00, 8'hFF, 4'd1);
    send_frame(1'b1, 3, 8'h80);
    send_item(REQ_READ, 8'h00, 8'h81);
    send_item(REQ_READ, 8'h00, 8'h80);
    load_config(8'hFF, 8'h00, 4'd15);
    send_frame(1'b1, 4, 8'h01);
    repeat (15) send_item(REQ_READ, 8'h00, 8'hFE);
    // a zero limit wraps the counter: the sixteenth miss unlocks
    load_config(8'h10, 8'h20, 4'd0);
    send_frame(1'b1, 2, 8'h33);
    repeat (16) send_item(REQ_READ, 8'h00, 8'hCC);
    send_frame(1'b1, 2, 8'h34);
    send_item(REQ_READ, 8'h00, 8'h34);
  endtask

  task automatic test_same_markers();
    load_config(8'h55, 8'h55, 4'd8);
    send_item(REQ_BYTE, 8'h55, 8'h00);
    send_item(REQ_BYTE, 8'h01, 8'h00);
    send_item(REQ_BYTE, 8'h02, 8'h00);
    send_item(REQ_BYTE, 8'h03, 8'h00);
    send_item(REQ_BYTE, 8'h55, 8'h00);
    send_item(REQ_READ, 8'h00, 8'h02);
  endtask

  task automatic test_backpressure();
    load_config(START_CHAR_RST, STOP_CHAR_RST, MISS_LIMIT_RST);
    no_idle       = 1'b1;
    long_hold_req = 1'b1;
    send_frame(1'b1, 10, 8'h6C);
    send_item(REQ_READ, 8'h00, 8'h6C);
    repeat (6) send_item(REQ_BYTE, plain_byte(), BYTE_W'($urandom));
    send_item(REQ_READ, 8'h00, 8'h00);
    wait_all_results();
    no_idle = 1'b0;
  endtask

  // Mostly well-formed frames with reads, plus noise and broken frames
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(DEPTH - 3, DEPTH + 2)
                                           : $urandom_range(2, 8);
        send_frame($urandom_range(0, 9) != 0, len, plain_byte());
        repeat ($urandom_range(0, 2))
          send_item(REQ_READ, BYTE_W'($urandom), code_m ^ 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 3) != 0) send_item(REQ_READ, BYTE_W'($urandom), code_m);
      end else if (r < 75) begin
        send_item(REQ_BYTE, BYTE_W'($urandom), BYTE_W'($urandom));
      end else if (r < 85) begin
        send_item(REQ_READ, BYTE_W'($urandom), BYTE_W'($urandom));
      end else if (r < 95) begin
        send_item(REQ_BYTE, start_m, BYTE_W'($urandom));
        repeat ($urandom_range(0, 3)) send_item(REQ_BYTE, plain_byte(), BYTE_W'($urandom));
        if ($urandom_range(0, 1) != 0) send_item(REQ_BYTE, stop_m, BYTE_W'($urandom));
      end else begin
        wait_all_results();
      end
    end
  endtask

  task automatic test_random();
    load_config(START_CHAR_RST, STOP_CHAR_RST, MISS_LIMIT_RST);
    run_random_phase(35);
    load_config(BYTE_W'($urandom), BYTE_W'($urandom), MISS_W'($urandom_range(1, 15)));
    run_random_phase(35);
    load_config(8'h00, 8'hFF, 4'd1);
    run_random_phase(30);
    no_idle = 1'b1;
    load_config(8'hFF, 8'h00, 4'd15);
    run_random_phase(30);
    no_idle = 1'b0;
    load_config(BYTE_W'($urandom), BYTE_W'($urandom), 4'd0);
    run_random_phase(30);
  endtask

  // Output stall: random bursts, none while no_idle is set, or one long hold when requested
  initial begin : out_stall_drive
    int unsigned r;
    int unsigned len;
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(1, 12);
        end else if (r < 90) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          len = $urandom_range(8, 30);
        end
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    rx_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d data %02h last %0b ovf %0b",
                             status_o, data_byte_o, last_o, overflow_o));
      end else begin
        want = due_results.pop_front();
        if (status_o !== want.status || data_byte_o !== want.data ||
            last_o !== want.last || overflow_o !== want.ovf)
          flag_error($sformatf({"mismatch: expected status %0d data %02h last %0b ovf %0b,",
                                " got status %0d data %02h last %0b ovf %0b"},
                               want.status, want.data, want.last, want.ovf,
                               status_o, data_byte_o, last_o, overflow_o));
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_seq
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_frames();
    test_overflow();
    test_miss_limit();
    test_same_markers();
    test_backpressure();
    test_random();
    wait_all_results();
    repeat (10) @(posedge clk_i);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", due_results.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
